### hdl/hdgs_pkg.sv
package hdgs_pkg;

    // Default grid size
    localparam int unsigned ROWS_DEF = 64;
    localparam int unsigned COLS_DEF = 64;

    // Field widths
    localparam int unsigned TEMP_W  = 24;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned STEPS_W = 16;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned CIDX_W  = 4;

    // Request actions
    localparam logic ACT_RUN  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Result status
    localparam logic STAT_OK        = 1'b0;
    localparam logic STAT_NOT_READY = 1'b1;

    // Register indexes on the configuration port
    localparam logic [CIDX_W-1:0] REG_EDGE_LEFT   = 4'd0;
    localparam logic [CIDX_W-1:0] REG_EDGE_RIGHT  = 4'd1;
    localparam logic [CIDX_W-1:0] REG_EDGE_TOP    = 4'd2;
    localparam logic [CIDX_W-1:0] REG_EDGE_BOTTOM = 4'd3;
    localparam logic [CIDX_W-1:0] REG_INTERIOR    = 4'd4;
    localparam logic [CIDX_W-1:0] REG_COEF_X      = 4'd5;
    localparam logic [CIDX_W-1:0] REG_COEF_Y      = 4'd6;
    localparam logic [CIDX_W-1:0] REG_STEP_COUNT  = 4'd7;

    // Register reset values
    localparam logic [TEMP_W-1:0]  RST_EDGE_LEFT   = 24'd409600;
    localparam logic [TEMP_W-1:0]  RST_EDGE_RIGHT  = 24'd204800;
    localparam logic [TEMP_W-1:0]  RST_EDGE_TOP    = 24'd307200;
    localparam logic [TEMP_W-1:0]  RST_EDGE_BOTTOM = 24'd102400;
    localparam logic [TEMP_W-1:0]  RST_INTERIOR    = 24'd81920;
    localparam logic [COEF_W-1:0]  RST_COEF_X      = 16'd15735;
    localparam logic [COEF_W-1:0]  RST_COEF_Y      = 16'd15735;
    localparam logic [STEPS_W-1:0] RST_STEP_COUNT  = 16'd1000;

    // Five-point neighbourhood of one cell
    typedef struct packed {
        logic signed [TEMP_W-1:0] old;
        logic signed [TEMP_W-1:0] up;
        logic signed [TEMP_W-1:0] dn;
        logic signed [TEMP_W-1:0] lf;
        logic signed [TEMP_W-1:0] rt;
    } t_nbr;

endpackage

### hdl/hdgs_ram.sv
module hdgs_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/hdgs_update.sv
module hdgs_update (
    input  logic                               i_clk,
    input  hdgs_pkg::t_nbr                     i_nbr,
    input  logic [hdgs_pkg::COEF_W-1:0]        i_coef_x,
    input  logic [hdgs_pkg::COEF_W-1:0]        i_coef_y,
    output logic signed [hdgs_pkg::TEMP_W-1:0] o_value
);
    import hdgs_pkg::*;

    localparam int unsigned D_W   = TEMP_W + 2;
    localparam int unsigned P_W   = D_W + COEF_W + 1;
    localparam int unsigned S_W   = P_W + 1;
    localparam int unsigned Q_W   = S_W - 16;
    localparam int unsigned N_W   = Q_W + 1;

    logic signed [D_W-1:0]    dv, dh;
    logic signed [P_W-1:0]    r_px, r_py;
    logic signed [TEMP_W-1:0] r_old;
    logic signed [S_W-1:0]    sum;
    logic signed [N_W-1:0]    nv;
    logic signed [TEMP_W-1:0] r_value;
    logic signed [N_W-1:0]    q_max, q_min;

    // Second differences along each axis
    assign dv = D_W'(i_nbr.up) + D_W'(i_nbr.dn) - (D_W'(i_nbr.old) <<< 1);
    assign dh = D_W'(i_nbr.lf) + D_W'(i_nbr.rt) - (D_W'(i_nbr.old) <<< 1);

    // Stage 1: weight by the coefficients
    always_ff @(posedge i_clk) begin
        r_px  <= $signed({1'b0, i_coef_x}) * P_W'(dv);
        r_py  <= $signed({1'b0, i_coef_y}) * P_W'(dh);
        r_old <= i_nbr.old;
    end

    // Stage 2: floor by 2^16 (arithmetic shift), add, saturate
    assign sum   = S_W'(r_px) + S_W'(r_py);
    assign nv    = N_W'(sum >>> 16) + N_W'(r_old);
    assign q_max = N_W'({1'b0, {(TEMP_W-1){1'b1}}});
    assign q_min = -q_max - N_W'(1);

    always_ff @(posedge i_clk) begin
        if (nv > q_max) begin
            r_value <= q_max[TEMP_W-1:0];
        end else if (nv < q_min) begin
            r_value <= q_min[TEMP_W-1:0];
        end else begin
            r_value <= nv[TEMP_W-1:0];
        end
    end

    assign o_value = r_value;

endmodule

### hdl/heat_diffusion_grid_solver.sv
// Run request: a load pass writes every cell of both grids, then step_count time steps
// each update every interior cell; each interior cell takes five reads of the single
// source memory port and then passes through the update pipeline. Read request: the
// cell is read in S_RDA and its value registered in S_RDD. One request at a time;
// results are strobed for one cycle and cannot be stalled. Synchronous reset restores
// register defaults and marks the grid as not ready; grid memories are not cleared.
module heat_diffusion_grid_solver #(
    parameter int unsigned ROWS = hdgs_pkg::ROWS_DEF,
    parameter int unsigned COLS = hdgs_pkg::COLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_action,
    input  logic [hdgs_pkg::POS_W-1:0]         i_row,
    input  logic [hdgs_pkg::POS_W-1:0]         i_col,
    output logic                               o_strobe,
    output logic signed [hdgs_pkg::TEMP_W-1:0] o_value,
    output logic                               o_status,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [hdgs_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [hdgs_pkg::TEMP_W-1:0]        i_cfg_data
);
    import hdgs_pkg::*;

    localparam int unsigned CELLS = ROWS * COLS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned CW    = $clog2(COLS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_RDA  = 3'd3;
    localparam logic [2:0] S_RDD  = 3'd4;

    // Configuration registers
    logic [TEMP_W-1:0]  r_left, r_right, r_top, r_bottom, r_inner;
    logic [COEF_W-1:0]  r_coef_x, r_coef_y;
    logic [STEPS_W-1:0] r_steps;

    // Control
    logic [2:0]         r_state;
    logic [RW-1:0]      r_r;
    logic [CW-1:0]      r_c;
    logic [AW-1:0]      r_addr;
    logic [2:0]         r_ph;
    logic [STEPS_W-1:0] r_n;
    logic               r_sel;
    logic               r_ready;
    logic               r_strobe;
    logic               r_status;
    logic signed [TEMP_W-1:0] r_value;
    logic signed [TEMP_W-1:0] r_old, r_up, r_dn, r_lf;

    // Memory interface
    logic [AW-1:0]     raddr;
    logic [TEMP_W-1:0] front_rdata, back_rdata, src_rdata;
    logic              front_we, back_we;
    logic [TEMP_W-1:0] wdata, load_val;
    t_nbr              nbr;
    logic signed [TEMP_W-1:0] upd_value;

    logic in_range;
    logic last_row, last_col, last_cell;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_value     = r_value;
    assign o_status    = r_status;

    assign in_range = ({3'b0, i_row} < 9'(ROWS)) && ({3'b0, i_col} < 9'(COLS));
    assign last_col = (r_c == CW'(COLS - 2));
    assign last_row = (r_r == RW'(ROWS - 2));
    assign last_cell = (r_r == RW'(ROWS - 1)) && (r_c == CW'(COLS - 1));

    // Initial value of the cell being loaded; top and bottom win at corners
    always_comb begin
        if (r_r == '0) begin
            load_val = r_top;
        end else if (r_r == RW'(ROWS - 1)) begin
            load_val = r_bottom;
        end else if (r_c == '0) begin
            load_val = r_left;
        end else if (r_c == CW'(COLS - 1)) begin
            load_val = r_right;
        end else begin
            load_val = r_inner;
        end
    end

    // Source read address: centre, up, down, left, right
    always_comb begin
        raddr = r_addr;
        if (r_state == S_STEP) begin
            case (r_ph)
                3'd1:    raddr = r_addr - AW'(COLS);
                3'd2:    raddr = r_addr + AW'(COLS);
                3'd3:    raddr = r_addr - AW'(1);
                3'd4:    raddr = r_addr + AW'(1);
                default: raddr = r_addr;
            endcase
        end
    end

    assign src_rdata = r_sel ? back_rdata : front_rdata;
    assign wdata     = (r_state == S_LOAD) ? load_val : upd_value;
    assign front_we  = (r_state == S_LOAD) || ((r_state == S_STEP) && (r_ph == 3'd7) && r_sel);
    assign back_we   = (r_state == S_LOAD) || ((r_state == S_STEP) && (r_ph == 3'd7) && !r_sel);

    hdgs_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_front (
        .i_clk   (i_clk),
        .i_we    (front_we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (front_rdata)
    );

    hdgs_ram #(.WIDTH(TEMP_W), .DEPTH(CELLS)) u_back (
        .i_clk   (i_clk),
        .i_we    (back_we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (back_rdata)
    );

    assign nbr.old = r_old;
    assign nbr.up  = r_up;
    assign nbr.dn  = r_dn;
    assign nbr.lf  = r_lf;
    assign nbr.rt  = src_rdata;

    hdgs_update u_update (
        .i_clk    (i_clk),
        .i_nbr    (nbr),
        .i_coef_x (r_coef_x),
        .i_coef_y (r_coef_y),
        .o_value  (upd_value)
    );

    // Neighbour capture, one per cycle after each of the first four reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_STEP) begin
            case (r_ph)
                3'd1:    r_old <= src_rdata;
                3'd2:    r_up  <= src_rdata;
                3'd3:    r_dn  <= src_rdata;
                3'd4:    r_lf  <= src_rdata;
                default: ;
            endcase
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= RST_EDGE_LEFT;
            r_right  <= RST_EDGE_RIGHT;
            r_top    <= RST_EDGE_TOP;
            r_bottom <= RST_EDGE_BOTTOM;
            r_inner  <= RST_INTERIOR;
            r_coef_x <= RST_COEF_X;
            r_coef_y <= RST_COEF_Y;
            r_steps  <= RST_STEP_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_EDGE_LEFT:   r_left   <= i_cfg_data;
                REG_EDGE_RIGHT:  r_right  <= i_cfg_data;
                REG_EDGE_TOP:    r_top    <= i_cfg_data;
                REG_EDGE_BOTTOM: r_bottom <= i_cfg_data;
                REG_INTERIOR:    r_inner  <= i_cfg_data;
                REG_COEF_X:      r_coef_x <= i_cfg_data[COEF_W-1:0];
                REG_COEF_Y:      r_coef_y <= i_cfg_data[COEF_W-1:0];
                REG_STEP_COUNT:  r_steps  <= i_cfg_data[STEPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sel    <= 1'b0;
            r_ready  <= 1'b0;
            r_strobe <= 1'b0;
            r_status <= STAT_OK;
            r_value  <= '0;
            r_r      <= '0;
            r_c      <= '0;
            r_addr   <= '0;
            r_ph     <= '0;
            r_n      <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_value  <= '0;
                        r_status <= STAT_OK;
                        if (i_action == ACT_RUN) begin
                            r_state <= S_LOAD;
                            r_sel   <= 1'b0;
                            r_r     <= '0;
                            r_c     <= '0;
                            r_addr  <= '0;
                        end else if (!r_ready) begin
                            r_status <= STAT_NOT_READY;
                            r_strobe <= 1'b1;
                        end else if (!in_range) begin
                            r_strobe <= 1'b1;
                        end else begin
                            r_addr  <= AW'(32'(i_row) * COLS + 32'(i_col));
                            r_state <= S_RDA;
                        end
                    end
                end
                S_LOAD: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_c == CW'(COLS - 1)) begin
                        r_c <= '0;
                        r_r <= r_r + RW'(1);
                    end else begin
                        r_c <= r_c + CW'(1);
                    end
                    if (last_cell) begin
                        r_r    <= RW'(1);
                        r_c    <= CW'(1);
                        r_addr <= AW'(COLS + 1);
                        r_ph   <= '0;
                        r_n    <= '0;
                        if (r_steps == '0) begin
                            r_state  <= S_IDLE;
                            r_ready  <= 1'b1;
                            r_strobe <= 1'b1;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd7) begin
                        if (!last_col) begin
                            r_c    <= r_c + CW'(1);
                            r_addr <= r_addr + AW'(1);
                        end else if (!last_row) begin
                            r_c    <= CW'(1);
                            r_r    <= r_r + RW'(1);
                            r_addr <= r_addr + AW'(3);
                        end else begin
                            // End of one time step: swap grids
                            r_sel  <= !r_sel;
                            r_r    <= RW'(1);
                            r_c    <= CW'(1);
                            r_addr <= AW'(COLS + 1);
                            r_n    <= r_n + STEPS_W'(1);
                            if ((17'(r_n) + 17'd1) == 17'(r_steps)) begin
                                r_state  <= S_IDLE;
                                r_ready  <= 1'b1;
                                r_strobe <= 1'b1;
                            end
                        end
                    end
                end
                S_RDA: begin
                    r_state <= S_RDD;
                end
                S_RDD: begin
                    r_value  <= src_rdata;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobed while still busy");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == STAT_NOT_READY)) |-> (o_value == '0))
        else $error("not-ready result carries a value");

    a_accept_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted request neither started nor answered");

    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_ready) |-> r_ready)
        else $error("grid ready flag dropped");

endmodule
